FILE: sv/assert_macros.svh
// Assertion macros for the checker file.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held (reset active low).
`define SPBF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Clocked assertion that is also checked while reset is held.
`define SPBF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/spbf_pkg.sv
// Shared types and constants of the spectral peak band finder.
// No dependencies; the interface, design and checker files refer to it by scoped names.
package spbf_pkg;

    // field widths fixed by the interface
    localparam int CMD_W  = 2;
    localparam int AMP_W  = 16;
    localparam int FREQ_W = 16;
    localparam int EIDX_W = 4;
    localparam int PEAK_W = 4;
    localparam int WIN_W  = 32;
    localparam int GRP_W  = 16;
    localparam int BC_W   = 5;
    localparam int CFG_W  = 16;
    localparam int CFGI_W = 2;

    // register reset values
    localparam logic [FREQ_W-1:0] CUTOFF_RST  = 16'd0;
    localparam logic [FREQ_W-1:0] NYQUIST_RST = 16'd22050;
    localparam logic [GRP_W-1:0]  GROUP_RST   = 16'd1;
    localparam logic [BC_W-1:0]   BANDS_RST   = 5'd16;

    // input commands
    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE     = 2'd0,
        CMD_WINDOW_END = 2'd1,
        CMD_STREAM_END = 2'd2,
        CMD_LOAD_EDGE  = 2'd3
    } t_cmd;

    // configuration register indexes
    typedef enum logic [CFGI_W-1:0] {
        CFG_CUTOFF     = 2'd0,
        CFG_NYQUIST    = 2'd1,
        CFG_GROUP      = 2'd2,
        CFG_BAND_COUNT = 2'd3
    } t_cfg_idx;

    // kind of token travelling down the cell chain
    typedef enum logic [1:0] {
        KIND_NOP    = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_EDGE   = 2'd2,
        KIND_REPORT = 2'd3
    } t_kind;

    // control part of a token
    typedef struct packed {
        t_kind kind;
        logic  claimed;   // sample already added to a band
    } t_ctrl;

endpackage

FILE: sv/spbf_if.sv
// Stream interfaces for the input items and the result items.
// Depends on spbf_pkg for the field widths.
interface spbf_in_if;
    logic                         valid;
    logic                         ready;
    logic [spbf_pkg::CMD_W-1:0]   cmd;
    logic [spbf_pkg::AMP_W-1:0]   amp;
    logic [spbf_pkg::FREQ_W-1:0]  freq;
    logic [spbf_pkg::EIDX_W-1:0]  edge_index;
    logic [spbf_pkg::FREQ_W-1:0]  edge_value;

    modport source (output valid, cmd, amp, freq, edge_index, edge_value, input ready);
    modport sink   (input valid, cmd, amp, freq, edge_index, edge_value, output ready);
endinterface

interface spbf_out_if;
    logic                         valid;
    logic                         ready;
    logic [spbf_pkg::PEAK_W-1:0]  best_band;
    logic [spbf_pkg::FREQ_W-1:0]  band_low;
    logic [spbf_pkg::FREQ_W-1:0]  band_high;
    logic [spbf_pkg::WIN_W-1:0]   start_window;
    logic [spbf_pkg::WIN_W-1:0]   end_window;

    modport source (output valid, best_band, band_low, band_high, start_window, end_window,
                    input ready);
    modport sink   (input valid, best_band, band_low, band_high, start_window, end_window,
                    output ready);
endinterface

FILE: sv/spectral_peak_band_finder_core.sv
// A result passes the front register, the row of MAX_BANDS cells and the output register, then is offered.
// Throughput: one input transaction per cycle; every item walks the row of MAX_BANDS cells.
// The row stalls only while a report at its end waits on an unaccepted held result.
// Synchronous active-low reset sets config to its reset values and clears counters, band energies,
// token kinds and the output valid; band edges are unknown until loaded.
module spectral_peak_band_finder_core #(
    parameter int MAX_BANDS    = 16,
    parameter int ENERGY_WIDTH = 40
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [spbf_pkg::CFGI_W-1:0]   i_cfg_idx,
    input  logic [spbf_pkg::CFG_W-1:0]    i_cfg_data,
    spbf_in_if.sink                       i_in,
    spbf_out_if.source                    o_out
);
    localparam int UW = $clog2(MAX_BANDS + 1);
    localparam int IW = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;

    // token links, stage 0 is the front register
    spbf_pkg::t_ctrl             c_ctrl      [0:MAX_BANDS];
    logic [spbf_pkg::AMP_W-1:0]  c_amp       [0:MAX_BANDS];
    logic [spbf_pkg::FREQ_W-1:0] c_freq      [0:MAX_BANDS];
    logic [UW-1:0]               c_used      [0:MAX_BANDS];
    logic [IW-1:0]               c_best      [0:MAX_BANDS];
    logic [ENERGY_WIDTH-1:0]     c_energy    [0:MAX_BANDS];
    logic [spbf_pkg::FREQ_W-1:0] c_low       [0:MAX_BANDS];
    logic [spbf_pkg::FREQ_W-1:0] c_high      [0:MAX_BANDS];
    logic [spbf_pkg::FREQ_W-1:0] c_prev      [0:MAX_BANDS];
    logic [spbf_pkg::WIN_W-1:0]  c_win_start [0:MAX_BANDS];
    logic [spbf_pkg::WIN_W-1:0]  c_win_end   [0:MAX_BANDS];

    logic                         en;
    logic                         tail_report;

    logic                         r_out_valid;
    logic [spbf_pkg::PEAK_W-1:0]  r_peak;
    logic [spbf_pkg::FREQ_W-1:0]  r_band_low;
    logic [spbf_pkg::FREQ_W-1:0]  r_band_high;
    logic [spbf_pkg::WIN_W-1:0]   r_start;
    logic [spbf_pkg::WIN_W-1:0]   r_end;

    // row advances unless a report would overwrite a held result
    assign tail_report = (c_ctrl[MAX_BANDS].kind == spbf_pkg::KIND_REPORT);
    assign en          = !(tail_report && r_out_valid && !o_out.ready);
    assign i_in.ready  = en;

    spbf_front #(
        .MAX_BANDS    (MAX_BANDS),
        .ENERGY_WIDTH (ENERGY_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_in.valid),
        .i_cmd        (i_in.cmd),
        .i_amp        (i_in.amp),
        .i_freq       (i_in.freq),
        .i_edge_index (i_in.edge_index),
        .i_edge_value (i_in.edge_value),
        .o_ctrl       (c_ctrl[0]),
        .o_amp        (c_amp[0]),
        .o_freq       (c_freq[0]),
        .o_used       (c_used[0]),
        .o_best       (c_best[0]),
        .o_energy     (c_energy[0]),
        .o_low        (c_low[0]),
        .o_high       (c_high[0]),
        .o_prev       (c_prev[0]),
        .o_win_start  (c_win_start[0]),
        .o_win_end    (c_win_end[0])
    );

    // row of band cells
    for (genvar k = 0; k < MAX_BANDS; k++) begin : g_cell
        spbf_cell #(
            .INDEX        (k),
            .MAX_BANDS    (MAX_BANDS),
            .ENERGY_WIDTH (ENERGY_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_en        (en),
            .i_ctrl      (c_ctrl[k]),
            .i_amp       (c_amp[k]),
            .i_freq      (c_freq[k]),
            .i_used      (c_used[k]),
            .i_best      (c_best[k]),
            .i_energy    (c_energy[k]),
            .i_low       (c_low[k]),
            .i_high      (c_high[k]),
            .i_prev      (c_prev[k]),
            .i_win_start (c_win_start[k]),
            .i_win_end   (c_win_end[k]),
            .o_ctrl      (c_ctrl[k+1]),
            .o_amp       (c_amp[k+1]),
            .o_freq      (c_freq[k+1]),
            .o_used      (c_used[k+1]),
            .o_best      (c_best[k+1]),
            .o_energy    (c_energy[k+1]),
            .o_low       (c_low[k+1]),
            .o_high      (c_high[k+1]),
            .o_prev      (c_prev[k+1]),
            .o_win_start (c_win_start[k+1]),
            .o_win_end   (c_win_end[k+1])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en && tail_report) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && tail_report) begin
            r_peak      <= spbf_pkg::PEAK_W'(c_best[MAX_BANDS]);
            r_band_low  <= c_low[MAX_BANDS];
            r_band_high <= c_high[MAX_BANDS];
            r_start     <= c_win_start[MAX_BANDS];
            r_end       <= c_win_end[MAX_BANDS];
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.best_band    = r_peak;
    assign o_out.band_low     = r_band_low;
    assign o_out.band_high    = r_band_high;
    assign o_out.start_window = r_start;
    assign o_out.end_window   = r_end;

endmodule

FILE: sv/spbf_front.sv
// Entry stage: configuration registers, command decode, window/group counters.
// Turns each accepted transaction into a chain token. Depends on spbf_pkg.
module spbf_front #(
    parameter int MAX_BANDS    = 16,
    parameter int ENERGY_WIDTH = 40
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [spbf_pkg::CFGI_W-1:0]      i_cfg_idx,
    input  logic [spbf_pkg::CFG_W-1:0]       i_cfg_data,
    // accepted input transaction
    input  logic                             i_valid,
    input  logic [spbf_pkg::CMD_W-1:0]       i_cmd,
    input  logic [spbf_pkg::AMP_W-1:0]       i_amp,
    input  logic [spbf_pkg::FREQ_W-1:0]      i_freq,
    input  logic [spbf_pkg::EIDX_W-1:0]      i_edge_index,
    input  logic [spbf_pkg::FREQ_W-1:0]      i_edge_value,
    // token into the first cell
    output spbf_pkg::t_ctrl                  o_ctrl,
    output logic [spbf_pkg::AMP_W-1:0]       o_amp,
    output logic [spbf_pkg::FREQ_W-1:0]      o_freq,
    output logic [$clog2(MAX_BANDS+1)-1:0]   o_used,
    output logic [(MAX_BANDS > 1 ? $clog2(MAX_BANDS) : 1)-1:0] o_best,
    output logic [ENERGY_WIDTH-1:0]          o_energy,
    output logic [spbf_pkg::FREQ_W-1:0]      o_low,
    output logic [spbf_pkg::FREQ_W-1:0]      o_high,
    output logic [spbf_pkg::FREQ_W-1:0]      o_prev,
    output logic [spbf_pkg::WIN_W-1:0]       o_win_start,
    output logic [spbf_pkg::WIN_W-1:0]       o_win_end
);
    localparam int UW = $clog2(MAX_BANDS + 1);

    // configuration
    logic [spbf_pkg::FREQ_W-1:0] r_cutoff;
    logic [spbf_pkg::FREQ_W-1:0] r_nyquist;
    logic [spbf_pkg::GRP_W-1:0]  r_group;
    logic [spbf_pkg::BC_W-1:0]   r_bands;

    // group tracking
    logic [spbf_pkg::GRP_W-1:0]  r_wig;
    logic [spbf_pkg::WIN_W-1:0]  r_gstart;
    logic [spbf_pkg::GRP_W-1:0]  n_wig;
    logic [spbf_pkg::WIN_W-1:0]  n_gstart;

    logic [spbf_pkg::GRP_W-1:0]  gsize;
    logic [spbf_pkg::GRP_W-1:0]  wig_inc;
    logic [spbf_pkg::WIN_W-1:0]  gend;
    logic [UW-1:0]               used;
    logic                        in_range;
    logic                        acc;
    spbf_pkg::t_kind             kind;

    // token register
    spbf_pkg::t_ctrl             r_ctrl;
    logic [spbf_pkg::AMP_W-1:0]  r_amp;
    logic [spbf_pkg::FREQ_W-1:0] r_freq;
    logic [UW-1:0]               r_used;
    logic [spbf_pkg::FREQ_W-1:0] r_low;
    logic [spbf_pkg::WIN_W-1:0]  r_win_start;
    logic [spbf_pkg::WIN_W-1:0]  r_win_end;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff  <= spbf_pkg::CUTOFF_RST;
            r_nyquist <= spbf_pkg::NYQUIST_RST;
            r_group   <= spbf_pkg::GROUP_RST;
            r_bands   <= spbf_pkg::BANDS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                spbf_pkg::CFG_CUTOFF:     r_cutoff  <= i_cfg_data;
                spbf_pkg::CFG_NYQUIST:    r_nyquist <= i_cfg_data;
                spbf_pkg::CFG_GROUP:      r_group   <= i_cfg_data;
                spbf_pkg::CFG_BAND_COUNT: r_bands   <= i_cfg_data[spbf_pkg::BC_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped band count and group size
    always_comb begin
        if (r_bands == '0) begin
            used = UW'(1);
        end else if (32'(r_bands) > MAX_BANDS) begin
            used = UW'(MAX_BANDS);
        end else begin
            used = UW'(r_bands);
        end
    end

    assign gsize    = (r_group == '0) ? spbf_pkg::GRP_W'(1) : r_group;
    assign wig_inc  = r_wig + spbf_pkg::GRP_W'(1);
    assign gend     = r_gstart + spbf_pkg::WIN_W'(gsize);
    assign in_range = (i_freq >= r_cutoff) && (i_freq <= r_nyquist);
    assign acc      = i_valid && i_en;

    // command decode and counter update
    always_comb begin
        kind     = spbf_pkg::KIND_NOP;
        n_wig    = r_wig;
        n_gstart = r_gstart;
        case (i_cmd)
            spbf_pkg::CMD_SAMPLE: begin
                if (in_range) begin
                    kind = spbf_pkg::KIND_SAMPLE;
                end
            end
            spbf_pkg::CMD_WINDOW_END: begin
                n_wig = wig_inc;
                if (wig_inc >= gsize) begin
                    kind     = spbf_pkg::KIND_REPORT;
                    n_wig    = '0;
                    n_gstart = gend;
                end
            end
            spbf_pkg::CMD_STREAM_END: begin
                if (r_wig != '0) begin
                    kind     = spbf_pkg::KIND_REPORT;
                    n_wig    = '0;
                    n_gstart = gend;
                end
            end
            spbf_pkg::CMD_LOAD_EDGE: begin
                kind = spbf_pkg::KIND_EDGE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wig    <= '0;
            r_gstart <= '0;
            r_ctrl   <= '{kind: spbf_pkg::KIND_NOP, claimed: 1'b0};
        end else if (i_en) begin
            r_ctrl.kind    <= i_valid ? kind : spbf_pkg::KIND_NOP;
            r_ctrl.claimed <= 1'b0;
            if (acc) begin
                r_wig    <= n_wig;
                r_gstart <= n_gstart;
            end
        end
    end

    // token payload; the edge index rides in the amplitude field
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_amp       <= (i_cmd == spbf_pkg::CMD_LOAD_EDGE) ?
                           spbf_pkg::AMP_W'(i_edge_index) : i_amp;
            r_freq      <= (i_cmd == spbf_pkg::CMD_LOAD_EDGE) ? i_edge_value : i_freq;
            r_used      <= used;
            r_low       <= r_cutoff;
            r_win_start <= r_gstart;
            r_win_end   <= gend;
        end
    end

    assign o_ctrl      = r_ctrl;
    assign o_amp       = r_amp;
    assign o_freq      = r_freq;
    assign o_used      = r_used;
    assign o_best      = '0;
    assign o_energy    = '0;
    assign o_low       = r_low;
    assign o_high      = '0;
    assign o_prev      = '0;
    assign o_win_start = r_win_start;
    assign o_win_end   = r_win_end;

endmodule

FILE: sv/spbf_cell.sv
// One band cell: holds a band's upper edge and energy, and hands the token on.
// Samples claim the first fitting band; reports carry a running argmax. Depends on spbf_pkg.
module spbf_cell #(
    parameter int INDEX        = 0,
    parameter int MAX_BANDS    = 16,
    parameter int ENERGY_WIDTH = 40
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  spbf_pkg::t_ctrl                  i_ctrl,
    input  logic [spbf_pkg::AMP_W-1:0]       i_amp,
    input  logic [spbf_pkg::FREQ_W-1:0]      i_freq,
    input  logic [$clog2(MAX_BANDS+1)-1:0]   i_used,
    input  logic [(MAX_BANDS > 1 ? $clog2(MAX_BANDS) : 1)-1:0] i_best,
    input  logic [ENERGY_WIDTH-1:0]          i_energy,
    input  logic [spbf_pkg::FREQ_W-1:0]      i_low,
    input  logic [spbf_pkg::FREQ_W-1:0]      i_high,
    input  logic [spbf_pkg::FREQ_W-1:0]      i_prev,
    input  logic [spbf_pkg::WIN_W-1:0]       i_win_start,
    input  logic [spbf_pkg::WIN_W-1:0]       i_win_end,
    output spbf_pkg::t_ctrl                  o_ctrl,
    output logic [spbf_pkg::AMP_W-1:0]       o_amp,
    output logic [spbf_pkg::FREQ_W-1:0]      o_freq,
    output logic [$clog2(MAX_BANDS+1)-1:0]   o_used,
    output logic [(MAX_BANDS > 1 ? $clog2(MAX_BANDS) : 1)-1:0] o_best,
    output logic [ENERGY_WIDTH-1:0]          o_energy,
    output logic [spbf_pkg::FREQ_W-1:0]      o_low,
    output logic [spbf_pkg::FREQ_W-1:0]      o_high,
    output logic [spbf_pkg::FREQ_W-1:0]      o_prev,
    output logic [spbf_pkg::WIN_W-1:0]       o_win_start,
    output logic [spbf_pkg::WIN_W-1:0]       o_win_end
);
    localparam int UW = $clog2(MAX_BANDS + 1);
    localparam int IW = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
    localparam logic [UW:0] K_POS  = (UW+1)'(INDEX);
    localparam logic [UW:0] K_NEXT = (UW+1)'(INDEX + 1);
    localparam logic        IS_FIRST = (INDEX == 0);

    logic [spbf_pkg::FREQ_W-1:0] r_band_edge;   // loaded by command, no reset
    logic [ENERGY_WIDTH-1:0]     r_energy;
    logic [ENERGY_WIDTH-1:0]     n_energy;

    spbf_pkg::t_ctrl             r_ctrl;
    logic [spbf_pkg::AMP_W-1:0]  r_amp;
    logic [spbf_pkg::FREQ_W-1:0] r_freq;
    logic [UW-1:0]               r_used;
    logic [IW-1:0]               r_best;
    logic [ENERGY_WIDTH-1:0]     r_best_energy;
    logic [spbf_pkg::FREQ_W-1:0] r_low;
    logic [spbf_pkg::FREQ_W-1:0] r_high;
    logic [spbf_pkg::FREQ_W-1:0] r_prev;
    logic [spbf_pkg::WIN_W-1:0]  r_win_start;
    logic [spbf_pkg::WIN_W-1:0]  r_win_end;

    logic                        in_use;
    logic                        is_last;
    logic                        hit;
    logic                        take;
    logic                        load;
    logic                        is_report;
    logic [ENERGY_WIDTH:0]       sum;

    assign in_use    = {1'b0, i_used} > K_POS;
    assign is_last   = {1'b0, i_used} == K_NEXT;
    assign is_report = (i_ctrl.kind == spbf_pkg::KIND_REPORT);

    // sample lands here if no lower band took it and the edge covers it or this is the last band in use
    assign hit  = (i_ctrl.kind == spbf_pkg::KIND_SAMPLE) && !i_ctrl.claimed && in_use &&
                  ((r_band_edge >= i_freq) || is_last);
    assign load = (i_ctrl.kind == spbf_pkg::KIND_EDGE) && (i_amp == spbf_pkg::AMP_W'(INDEX));
    // strictly greater keeps the lowest index on ties
    assign take = is_report && (IS_FIRST || (in_use && (r_energy > i_energy)));

    // saturating accumulate
    assign sum = {1'b0, r_energy} + (ENERGY_WIDTH+1)'(i_amp);

    always_comb begin
        n_energy = r_energy;
        if (hit) begin
            n_energy = sum[ENERGY_WIDTH] ? '1 : sum[ENERGY_WIDTH-1:0];
        end
        if (is_report) begin
            n_energy = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_energy <= '0;
            r_ctrl   <= '{kind: spbf_pkg::KIND_NOP, claimed: 1'b0};
        end else if (i_en) begin
            r_energy       <= n_energy;
            r_ctrl.kind    <= i_ctrl.kind;
            r_ctrl.claimed <= i_ctrl.claimed | hit;
        end
    end

    // edge store and token payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (load) begin
                r_band_edge <= i_freq;
            end
            r_amp         <= i_amp;
            r_freq        <= i_freq;
            r_used        <= i_used;
            r_best        <= take ? IW'(INDEX) : i_best;
            r_best_energy <= take ? r_energy : i_energy;
            r_low         <= (take && !IS_FIRST) ? i_prev : i_low;
            r_high        <= take ? r_band_edge : i_high;
            r_prev        <= r_band_edge;
            r_win_start   <= i_win_start;
            r_win_end     <= i_win_end;
        end
    end

    assign o_ctrl      = r_ctrl;
    assign o_amp       = r_amp;
    assign o_freq      = r_freq;
    assign o_used      = r_used;
    assign o_best      = r_best;
    assign o_energy    = r_best_energy;
    assign o_low       = r_low;
    assign o_high      = r_high;
    assign o_prev      = r_prev;
    assign o_win_start = r_win_start;
    assign o_win_end   = r_win_end;

endmodule

FILE: sv/spbf_checker.sv
// Port-level checks of the peak band finder, bound to the top level.
// Depends on assert_macros.svh, spbf_pkg and spectral_peak_band_finder_core.
`include "assert_macros.svh"

module spbf_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [spbf_pkg::WIN_W-1:0]    out_start,
    input logic [spbf_pkg::WIN_W-1:0]    out_end
);
    // a held result stays offered
    `SPBF_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

    // input is only refused because a result is waiting
    `SPBF_ASSERT(a_ready_cause, clk, rst_n, !in_ready |-> out_valid && !out_ready, "input stalled without a held result")

    // groups tile the window count: a result directly after another starts where it ended
    `SPBF_ASSERT(a_groups_tile, clk, rst_n, $past(out_valid && out_ready) && out_valid |-> out_start == $past(out_end), "window span not contiguous")

    // a group spans at least one window
    `SPBF_ASSERT(a_span_nonzero, clk, rst_n, out_valid |-> out_end != out_start, "empty window span")

    // nothing is offered right after reset
    `SPBF_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind spectral_peak_band_finder_core spbf_checker u_spbf_checker (
    .clk       (i_clk),
    .rst_n     (i_rst_n),
    .in_ready  (i_in.ready),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .out_start (o_out.start_window),
    .out_end   (o_out.end_window)
);
